// File: rtl/sfo_pkg.sv
package sfo_pkg;

  // Q8.24 unit and fixed constants of the exponential evaluation.
  localparam logic [24:0] ONE_Q24   = 25'd16777216;
  localparam logic [24:0] LOG2E_Q24 = 25'd24204406;
  localparam longint unsigned LN2_Q32 = 64'd2977044472;

  // Width of the divider's partial remainder and divisor.
  localparam int DIV_W = 26;

  localparam int CFG_DATA_W = 31;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRICTION_BREAK   = 3'd0,
    REG_FRICTION_COULOMB = 3'd1,
    REG_INV_VEL_LIMIT    = 3'd2,
    REG_REG_GAIN         = 3'd3,
    REG_TOTAL_INERTIA    = 3'd4,
    REG_TORQUE_GAIN      = 3'd5,
    REG_VELOCITY_GAIN    = 3'd6,
    REG_OFFSET_LIMIT     = 3'd7
  } cfg_reg_t;

  localparam logic [CFG_DATA_W-1:0] RST_FRICTION_BREAK   = 31'd3088411;
  localparam logic [CFG_DATA_W-1:0] RST_FRICTION_COULOMB = 31'd1626306;
  localparam logic [CFG_DATA_W-1:0] RST_INV_VEL_LIMIT    = 31'd57565000;
  localparam logic [CFG_DATA_W-1:0] RST_REG_GAIN         = 31'd335544320;
  localparam logic [CFG_DATA_W-1:0] RST_TOTAL_INERTIA    = 31'd100759;
  localparam logic [CFG_DATA_W-1:0] RST_TORQUE_GAIN      = 31'd262000;
  localparam logic [CFG_DATA_W-1:0] RST_VELOCITY_GAIN    = 31'd550000;
  localparam logic [CFG_DATA_W-1:0] RST_OFFSET_LIMIT     = 31'd1970000;

  // Truncating unsigned quotient by shift and subtract, for the table build.
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned q;
    longint unsigned rem;
    int b;
    q = 64'd0;
    rem = 64'd0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem = rem - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Table entry k of 2^(-k/2^tb) in Q1.24, from a 20-term series in Q.32.
  // Evaluated at elaboration only.
  function automatic logic [24:0] pow2_entry(input int unsigned k, input int unsigned tb);
    longint unsigned z;
    longint unsigned term;
    longint unsigned jj;
    longint sum;
    logic [63:0] rounded;
    int j;
    z = (longint'(k) * LN2_Q32) >> tb;
    term = 64'd1 << 32;
    sum = longint'(64'd1 << 32);
    for (j = 1; j <= 20; j++) begin
      jj = longint'(j);
      term = udiv64((term * z) >> 32, jj);
      if (j[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    rounded = (64'(sum) + 64'd128) >> 8;
    if (k == 0) begin
      rounded = 64'(ONE_Q24);
    end
    return rounded[24:0];
  endfunction

endpackage

// File: rtl/sfo_div_step.sv
module sfo_div_step
  import sfo_pkg::*;
(
  input  logic [DIV_W-1:0] rem_in,
  input  logic             num_bit,
  input  logic [DIV_W-1:0] den,
  output logic [DIV_W-1:0] rem_out,
  output logic             q_bit
);

  logic [DIV_W:0] trial;
  logic [DIV_W:0] diff;

  // One restoring step: bring in the next dividend bit and try to subtract.
  always_comb begin
    trial = {rem_in, num_bit};
    diff  = trial - {1'b0, den};
    if (trial >= {1'b0, den}) begin
      q_bit   = 1'b1;
      rem_out = diff[DIV_W-1:0];
    end else begin
      q_bit   = 1'b0;
      rem_out = trial[DIV_W-1:0];
    end
  end

endmodule

// File: rtl/servo_feedforward_offset.sv
// Stribeck friction feedforward: turns one goal point (velocity, acceleration
// and external torque, all signed Q8.24) into a clamped servo position offset
// and a saturation flag.
//
// The input channel and the result channel each use valid and stall; a
// transaction completes on a rising edge with valid high and stall low. The
// block is a 38-stage pipeline and takes one transaction every cycle while
// the result side is not stalled. The depth is set mostly by the tanh
// quotient, which is formed one bit per stage over 25 stages, behind seven
// input, product, table and setup stages and ahead of six stages of
// products, sums and the clamp.
//
// When the receiver stalls, only the stages that hold valid data stall; empty
// stages keep filling, so the input side stalls only once the pipeline is full
// from its head. Nothing is dropped or repeated.
//
// Reset empties the pipeline and loads the eight configuration registers with
// their defaults. The user writes configuration through cfg_wen, cfg_index
// and cfg_wdata while no transaction is in flight; the block does not check.
module servo_feedforward_offset
  import sfo_pkg::*;
#(
  parameter int FUNC_TABLE_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [31:0]    in_goal_velocity,
  input  logic signed [31:0]    in_goal_acceleration,
  input  logic signed [31:0]    in_goal_torque,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [31:0]    out_angular_offset,
  output logic                  out_saturated,

  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Table geometry follows from the number of index bits.
  localparam int TBL_N = 1 << FUNC_TABLE_BITS;
  localparam int RW    = 24 - FUNC_TABLE_BITS;
  localparam int IW    = FUNC_TABLE_BITS + 1;
  localparam int DRW   = 25 + RW;

  // Stage numbering.
  localparam int ST_IN     = 0;
  localparam int ST_MUL    = 1;
  localparam int ST_EXPT   = 2;
  localparam int ST_LUT    = 3;
  localparam int ST_INTERP = 4;
  localparam int ST_SHIFT  = 5;
  localparam int ST_LEVEL  = 6;
  localparam int ST_DIV0   = 7;
  localparam int DIV_STEPS = 25;
  localparam int ST_STAT   = ST_DIV0 + DIV_STEPS;
  localparam int ST_TSUM   = ST_STAT + 1;
  localparam int ST_TMUL   = ST_TSUM + 1;
  localparam int ST_TADD   = ST_TMUL + 1;
  localparam int ST_RAW    = ST_TADD + 1;
  localparam int ST_OUT    = ST_RAW + 1;
  localparam int NS        = ST_OUT + 1;

  // Everything an item carries down the pipeline. Each stage fills in the
  // fields it computes; fields nobody reads later are trimmed by synthesis.
  typedef struct packed {
    logic                  vneg;
    logic                  aneg;
    logic [31:0]           tg;
    logic [31:0]           av;
    logic [31:0]           am;
    logic [1:0][38:0]      ex_x;
    logic [37:0]           inert;
    logic [37:0]           vterm;
    logic [1:0][29:0]      ex_t;
    logic [1:0]            ex_big;
    logic [1:0][5:0]       ex_n;
    logic [1:0]            ex_zero;
    logic [1:0][24:0]      ex_hi;
    logic [1:0][24:0]      ex_d;
    logic [1:0][RW-1:0]    ex_r;
    logic [1:0][24:0]      ex_val;
    logic [1:0][24:0]      ex_out;
    logic [55:0]           lb;
    logic [55:0]           lc;
    logic [DIV_W-1:0]      drem;
    logic [24:0]           dnum;
    logic [DIV_W-1:0]      dden;
    logic [24:0]           dq;
    logic [30:0]           level;
    logic [30:0]           stat;
    logic                  tneg;
    logic [39:0]           tmag;
    logic [46:0]           tph;
    logic [30:0]           tpl;
    logic [47:0]           tterm;
    logic [49:0]           raw;
    logic [31:0]           offset;
    logic                  sat;
  } pipe_t;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] friction_break_r;
  logic [CFG_DATA_W-1:0] friction_coulomb_r;
  logic [CFG_DATA_W-1:0] inv_vel_limit_r;
  logic [CFG_DATA_W-1:0] reg_gain_r;
  logic [CFG_DATA_W-1:0] total_inertia_r;
  logic [CFG_DATA_W-1:0] torque_gain_r;
  logic [CFG_DATA_W-1:0] velocity_gain_r;
  logic [CFG_DATA_W-1:0] offset_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      friction_break_r   <= RST_FRICTION_BREAK;
      friction_coulomb_r <= RST_FRICTION_COULOMB;
      inv_vel_limit_r    <= RST_INV_VEL_LIMIT;
      reg_gain_r         <= RST_REG_GAIN;
      total_inertia_r    <= RST_TOTAL_INERTIA;
      torque_gain_r      <= RST_TORQUE_GAIN;
      velocity_gain_r    <= RST_VELOCITY_GAIN;
      offset_limit_r     <= RST_OFFSET_LIMIT;
    end else if (cfg_wen) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRICTION_BREAK:   friction_break_r   <= cfg_wdata;
        REG_FRICTION_COULOMB: friction_coulomb_r <= cfg_wdata;
        REG_INV_VEL_LIMIT:    inv_vel_limit_r    <= cfg_wdata;
        REG_REG_GAIN:         reg_gain_r         <= cfg_wdata;
        REG_TOTAL_INERTIA:    total_inertia_r    <= cfg_wdata;
        REG_TORQUE_GAIN:      torque_gain_r      <= cfg_wdata;
        REG_VELOCITY_GAIN:    velocity_gain_r    <= cfg_wdata;
        REG_OFFSET_LIMIT:     offset_limit_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Constant table of 2^(-k/TBL_N), built at elaboration.
  logic [24:0] rom_w [TBL_N+1];

  for (genvar k = 0; k <= TBL_N; k++) begin : g_rom
    localparam logic [24:0] ENTRY = pow2_entry(k, FUNC_TABLE_BITS);
    assign rom_w[k] = ENTRY;
  end

  // Pipeline registers and per-stage advance. A stage advances when it is
  // empty or when the stage after it advances.
  pipe_t         s_r   [NS];
  pipe_t         s_nxt [NS];
  logic [NS-1:0] v_r;
  logic [NS-1:0] v_in;
  logic [NS:0]   adv;

  assign adv[NS] = !out_stall;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    assign adv[k] = !v_r[k] || adv[k+1];
    if (k == 0) begin : g_head
      assign v_in[k] = in_valid;
    end else begin : g_body
      assign v_in[k] = v_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv[k]) begin
        v_r[k] <= v_in[k];
      end
      if (adv[k]) begin
        s_r[k] <= s_nxt[k];
      end
    end
  end

  assign in_stall = !adv[0];

  // Input stage: magnitudes and signs.
  always_comb begin
    s_nxt[ST_IN] = '0;
    s_nxt[ST_IN].vneg = in_goal_velocity[31];
    s_nxt[ST_IN].aneg = in_goal_acceleration[31];
    s_nxt[ST_IN].tg   = in_goal_torque;
    s_nxt[ST_IN].av   = in_goal_velocity[31] ? (32'd0 - in_goal_velocity) : in_goal_velocity;
    s_nxt[ST_IN].am   = in_goal_acceleration[31] ?
                        (32'd0 - in_goal_acceleration) : in_goal_acceleration;
  end

  // Four parallel Q8.24 products on magnitudes, truncated.
  logic [62:0] p_xb;
  logic [62:0] p_y;
  logic [62:0] p_in;
  logic [62:0] p_v;

  always_comb begin
    s_nxt[ST_MUL] = s_r[ST_MUL-1];
    p_xb = {31'd0, s_r[ST_MUL-1].av} * {32'd0, inv_vel_limit_r};
    p_y  = {31'd0, s_r[ST_MUL-1].av} * {32'd0, reg_gain_r};
    p_in = {31'd0, s_r[ST_MUL-1].am} * {32'd0, total_inertia_r};
    p_v  = {31'd0, s_r[ST_MUL-1].av} * {32'd0, velocity_gain_r};
    s_nxt[ST_MUL].ex_x[0] = {1'b0, p_xb[61:24]};
    // tanh needs exp(-2y).
    s_nxt[ST_MUL].ex_x[1] = {p_y[61:24], 1'b0};
    s_nxt[ST_MUL].inert   = p_in[61:24];
    s_nxt[ST_MUL].vterm   = p_v[61:24];
  end

  // Both exponential lanes: lane 0 gives beta, lane 1 gives the tanh term.
  logic [1:0][53:0] p_t;

  always_comb begin
    s_nxt[ST_EXPT] = s_r[ST_EXPT-1];
    for (int l = 0; l < 2; l++) begin
      p_t[l] = {25'd0, s_r[ST_EXPT-1].ex_x[l][28:0]} * {29'd0, LOG2E_Q24};
      s_nxt[ST_EXPT].ex_t[l]   = p_t[l][53:24];
      // Arguments of 32.0 or more give zero.
      s_nxt[ST_EXPT].ex_big[l] = |s_r[ST_EXPT-1].ex_x[l][38:29];
    end
  end

  // Split into integer shift and fraction; read the two neighboring entries.
  logic [1:0][IW-1:0] idx_hi;
  logic [1:0][IW-1:0] idx_lo;
  logic [1:0][24:0]   ent_hi;
  logic [1:0][24:0]   ent_lo;

  always_comb begin
    s_nxt[ST_LUT] = s_r[ST_LUT-1];
    for (int l = 0; l < 2; l++) begin
      idx_hi[l] = {1'b0, s_r[ST_LUT-1].ex_t[l][23:RW]};
      idx_lo[l] = idx_hi[l] + 1'b1;
      ent_hi[l] = rom_w[idx_hi[l]];
      ent_lo[l] = rom_w[idx_lo[l]];
      s_nxt[ST_LUT].ex_n[l]    = s_r[ST_LUT-1].ex_t[l][29:24];
      s_nxt[ST_LUT].ex_zero[l] = s_r[ST_LUT-1].ex_big[l] ||
                                 (s_r[ST_LUT-1].ex_t[l][29:24] > 6'd24);
      s_nxt[ST_LUT].ex_hi[l]   = ent_hi[l];
      s_nxt[ST_LUT].ex_d[l]    = ent_hi[l] - ent_lo[l];
      s_nxt[ST_LUT].ex_r[l]    = s_r[ST_LUT-1].ex_t[l][RW-1:0];
    end
  end

  // Linear interpolation between the two entries, truncated.
  logic [1:0][DRW-1:0] p_dr;

  always_comb begin
    s_nxt[ST_INTERP] = s_r[ST_INTERP-1];
    for (int l = 0; l < 2; l++) begin
      p_dr[l] = DRW'(s_r[ST_INTERP-1].ex_d[l]) * DRW'(s_r[ST_INTERP-1].ex_r[l]);
      s_nxt[ST_INTERP].ex_val[l] = s_r[ST_INTERP-1].ex_hi[l] - p_dr[l][DRW-1:RW];
    end
  end

  // Apply the integer part as a right shift.
  always_comb begin
    s_nxt[ST_SHIFT] = s_r[ST_SHIFT-1];
    for (int l = 0; l < 2; l++) begin
      s_nxt[ST_SHIFT].ex_out[l] = s_r[ST_SHIFT-1].ex_zero[l] ? 25'd0 :
                                  (s_r[ST_SHIFT-1].ex_val[l] >> s_r[ST_SHIFT-1].ex_n[l]);
    end
  end

  // Blend products for the static level, and the tanh quotient setup:
  // (1 - e) << 24 divided by (1 + e).
  logic [24:0] one_m_beta;
  logic [24:0] one_m_e;

  always_comb begin
    s_nxt[ST_LEVEL] = s_r[ST_LEVEL-1];
    one_m_beta = ONE_Q24 - s_r[ST_LEVEL-1].ex_out[0];
    one_m_e    = ONE_Q24 - s_r[ST_LEVEL-1].ex_out[1];
    s_nxt[ST_LEVEL].lb   = {31'd0, s_r[ST_LEVEL-1].ex_out[0]} * {25'd0, friction_break_r};
    s_nxt[ST_LEVEL].lc   = {31'd0, one_m_beta} * {25'd0, friction_coulomb_r};
    s_nxt[ST_LEVEL].drem = {2'b00, one_m_e[24:1]};
    s_nxt[ST_LEVEL].dnum = {one_m_e[0], 24'd0};
    s_nxt[ST_LEVEL].dden = {1'b0, ONE_Q24} + {1'b0, s_r[ST_LEVEL-1].ex_out[1]};
    s_nxt[ST_LEVEL].dq   = '0;
  end

  // Restoring divider, one quotient bit per stage.
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    logic [DIV_W-1:0] rem_o;
    logic             q_o;
    logic [56:0]      lsum;

    sfo_div_step u_step (
      .rem_in  (s_r[ST_DIV0+g-1].drem),
      .num_bit (s_r[ST_DIV0+g-1].dnum[24]),
      .den     (s_r[ST_DIV0+g-1].dden),
      .rem_out (rem_o),
      .q_bit   (q_o)
    );

    always_comb begin
      s_nxt[ST_DIV0+g] = s_r[ST_DIV0+g-1];
      s_nxt[ST_DIV0+g].drem = rem_o;
      s_nxt[ST_DIV0+g].dnum = {s_r[ST_DIV0+g-1].dnum[23:0], 1'b0};
      s_nxt[ST_DIV0+g].dq   = {s_r[ST_DIV0+g-1].dq[23:0], q_o};
      lsum = {1'b0, s_r[ST_DIV0+g-1].lb} + {1'b0, s_r[ST_DIV0+g-1].lc};
      if (g == 0) begin
        s_nxt[ST_DIV0+g].level = lsum[54:24];
      end
    end
  end

  // Static friction: level times tanh.
  logic [55:0] p_stat;

  always_comb begin
    s_nxt[ST_STAT] = s_r[ST_STAT-1];
    p_stat = {25'd0, s_r[ST_STAT-1].level} * {31'd0, s_r[ST_STAT-1].dq};
    s_nxt[ST_STAT].stat = p_stat[54:24];
  end

  // Motor torque sum, kept at 41 bits so nothing wraps.
  logic [40:0] tsum;
  logic [40:0] t_stat;
  logic [40:0] t_inert;
  logic [40:0] t_neg;

  always_comb begin
    s_nxt[ST_TSUM] = s_r[ST_TSUM-1];
    t_stat  = s_r[ST_TSUM-1].vneg ? (41'd0 - {10'd0, s_r[ST_TSUM-1].stat}) :
                                    {10'd0, s_r[ST_TSUM-1].stat};
    t_inert = s_r[ST_TSUM-1].aneg ? (41'd0 - {3'd0, s_r[ST_TSUM-1].inert}) :
                                    {3'd0, s_r[ST_TSUM-1].inert};
    tsum    = {{9{s_r[ST_TSUM-1].tg[31]}}, s_r[ST_TSUM-1].tg} + t_stat + t_inert;
    t_neg   = 41'd0 - tsum;
    s_nxt[ST_TSUM].tneg = tsum[40];
    s_nxt[ST_TSUM].tmag = tsum[40] ? t_neg[39:0] : tsum[39:0];
  end

  // Torque gain product split into integer and fraction partial products.
  logic [46:0] p_th;
  logic [54:0] p_tl;

  always_comb begin
    s_nxt[ST_TMUL] = s_r[ST_TMUL-1];
    p_th = {31'd0, s_r[ST_TMUL-1].tmag[39:24]} * {16'd0, torque_gain_r};
    p_tl = {31'd0, s_r[ST_TMUL-1].tmag[23:0]} * {24'd0, torque_gain_r};
    s_nxt[ST_TMUL].tph = p_th;
    s_nxt[ST_TMUL].tpl = p_tl[54:24];
  end

  always_comb begin
    s_nxt[ST_TADD] = s_r[ST_TADD-1];
    s_nxt[ST_TADD].tterm = {1'b0, s_r[ST_TADD-1].tph} + {17'd0, s_r[ST_TADD-1].tpl};
  end

  // Raw offset: signed torque term plus signed velocity term.
  logic [49:0] r_t;
  logic [49:0] r_v;

  always_comb begin
    s_nxt[ST_RAW] = s_r[ST_RAW-1];
    r_t = s_r[ST_RAW-1].tneg ? (50'd0 - {2'd0, s_r[ST_RAW-1].tterm}) :
                               {2'd0, s_r[ST_RAW-1].tterm};
    r_v = s_r[ST_RAW-1].vneg ? (50'd0 - {12'd0, s_r[ST_RAW-1].vterm}) :
                               {12'd0, s_r[ST_RAW-1].vterm};
    s_nxt[ST_RAW].raw = r_t + r_v;
  end

  // Clamp to the supply limit; this stage is the output register.
  logic [49:0] lim_p;
  logic [49:0] lim_n;

  always_comb begin
    s_nxt[ST_OUT] = s_r[ST_OUT-1];
    lim_p = {19'd0, offset_limit_r};
    lim_n = 50'd0 - lim_p;
    if ($signed(s_r[ST_OUT-1].raw) > $signed(lim_p)) begin
      s_nxt[ST_OUT].offset = lim_p[31:0];
      s_nxt[ST_OUT].sat    = 1'b1;
    end else if ($signed(s_r[ST_OUT-1].raw) < $signed(lim_n)) begin
      s_nxt[ST_OUT].offset = lim_n[31:0];
      s_nxt[ST_OUT].sat    = 1'b1;
    end else begin
      s_nxt[ST_OUT].offset = s_r[ST_OUT-1].raw[31:0];
      s_nxt[ST_OUT].sat    = 1'b0;
    end
  end

  assign out_valid          = v_r[ST_OUT];
  assign out_angular_offset = s_r[ST_OUT].offset;
  assign out_saturated      = s_r[ST_OUT].sat;

`ifndef SYNTHESIS
  // A full stage that cannot hand on its item keeps it.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ST_STAT] && !adv[ST_STAT+1] |=> v_r[ST_STAT] && $stable(s_r[ST_STAT].dq))
    else $error("stalled stage lost its item");

  // The input side stalls only when the head stage is occupied.
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v_r[ST_IN])
    else $error("input stalled with empty head stage");

  // Exponential results never exceed one.
  a_exp: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ST_SHIFT] |-> (s_r[ST_SHIFT].ex_out[0] <= ONE_Q24) &&
                      (s_r[ST_SHIFT].ex_out[1] <= ONE_Q24))
    else $error("exponential above one");

  // The partial remainder stays below the divisor, and tanh stays within one.
  a_div: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ST_STAT-1] |-> (s_r[ST_STAT-1].drem < s_r[ST_STAT-1].dden) &&
                       (s_r[ST_STAT-1].dq <= ONE_Q24))
    else $error("divider out of range");
`endif

endmodule
